/* hdl/sxtok_pkg.sv */
// Shared types and codes for the s-expression tokenizer.
// Holds token and parse state layouts used by the step logic and the top level.
// No dependencies.
`default_nettype none

package sxtok_pkg;

   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0a;
   localparam logic [7:0] CHAR_CR     = 8'h0d;

   localparam int unsigned ATOM_LEN_W = 13;
   localparam int unsigned MAX_TOKENS = 3;

   typedef enum logic [2:0] {
      TOK_OPEN,
      TOK_CLOSE,
      TOK_BYTE,
      TOK_END,
      TOK_DONE,
      TOK_ERROR
   } tok_kind_type;

   typedef enum logic [1:0] {
      ATOM_BASIC,
      ATOM_DQ,
      ATOM_SQ
   } atom_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_UNMATCHED,
      ERR_OVERFLOW,
      ERR_TRUNC,
      ERR_OUTSIDE
   } err_type;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_BASIC,
      MODE_DQ,
      MODE_SQ_WAIT,
      MODE_SQ_LIST
   } mode_type;

   typedef struct packed {
      tok_kind_type  kind;
      logic [7:0]    ch;
      atom_kind_type akind;
      logic [7:0]    depth;
      err_type       err;
   } token_type;

   typedef struct packed {
      mode_type                mode;
      logic [7:0]              depth;
      logic [7:0]              qdepth;
      logic [ATOM_LEN_W-1:0]   count;
      logic                    trunc;
   } state_type;

   typedef token_type [MAX_TOKENS-1:0] token_list_type;

endpackage

`default_nettype wire

/* hdl/sxtok_step.sv */
// Next-state and token logic for one character of the s-expression tokenizer.
// Purely combinational; depends on sxtok_pkg.
`default_nettype none

module sxtok_step (
   input  wire sxtok_pkg::state_type                     state_i,
   input  wire [7:0]                                     char_i,
   input  wire [sxtok_pkg::ATOM_LEN_W-1:0]               limit_i,
   input  wire [7:0]                                     depth_cap_i,
   output sxtok_pkg::state_type                          state_o,
   output sxtok_pkg::token_list_type                     tokens_o,
   output logic [1:0]                                    count_o
);

   typedef struct packed {
      sxtok_pkg::state_type      st;
      sxtok_pkg::token_list_type tok;
      logic [1:0]                n;
   } work_type;

   function automatic logic is_atom(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
             (c >= 8'h30 && c <= 8'h39) || c == sxtok_pkg::CHAR_BANG;
   endfunction

   function automatic work_type f_emit(input work_type w,
                                       input sxtok_pkg::tok_kind_type kind,
                                       input logic [7:0] ch,
                                       input sxtok_pkg::atom_kind_type ak,
                                       input sxtok_pkg::err_type err);
      work_type r;
      r = w;
      if (w.n != 2'(sxtok_pkg::MAX_TOKENS)) begin
         r.tok[w.n].kind  = kind;
         r.tok[w.n].ch    = ch;
         r.tok[w.n].akind = ak;
         r.tok[w.n].depth = w.st.depth;
         r.tok[w.n].err   = err;
         r.n = w.n + 2'd1;
      end
      return r;
   endfunction

   function automatic work_type f_add_byte(input work_type w, input logic [7:0] c,
                                           input logic [sxtok_pkg::ATOM_LEN_W-1:0] lim);
      work_type r;
      r = w;
      if (w.st.count < lim) begin
         r = f_emit(r, sxtok_pkg::TOK_BYTE, c, sxtok_pkg::ATOM_BASIC, sxtok_pkg::ERR_NONE);
         r.st.count = w.st.count + 13'd1;
      end else begin
         r.st.trunc = 1'b1;
      end
      return r;
   endfunction

   function automatic work_type f_begin(input work_type w, input sxtok_pkg::mode_type m);
      work_type r;
      r = w;
      r.st.mode  = m;
      r.st.count = '0;
      r.st.trunc = 1'b0;
      return r;
   endfunction

   function automatic work_type f_end_atom(input work_type w,
                                           input sxtok_pkg::atom_kind_type ak);
      work_type r;
      r = f_emit(w, sxtok_pkg::TOK_END, 8'h00, ak,
                 w.st.trunc ? sxtok_pkg::ERR_TRUNC : sxtok_pkg::ERR_NONE);
      if (w.st.depth == 8'd0) begin
         r = f_emit(r, sxtok_pkg::TOK_ERROR, 8'h00, sxtok_pkg::ATOM_BASIC,
                    sxtok_pkg::ERR_OUTSIDE);
      end
      r.st.mode  = sxtok_pkg::MODE_IDLE;
      r.st.count = '0;
      r.st.trunc = 1'b0;
      return r;
   endfunction

   function automatic work_type f_idle(input work_type w, input logic [7:0] c,
                                       input logic [7:0] cap,
                                       input logic [sxtok_pkg::ATOM_LEN_W-1:0] lim);
      work_type r;
      r = w;
      r.st.mode = sxtok_pkg::MODE_IDLE;
      if (c == sxtok_pkg::CHAR_LPAREN) begin
         if (w.st.depth >= cap) begin
            r = f_emit(r, sxtok_pkg::TOK_ERROR, 8'h00, sxtok_pkg::ATOM_BASIC,
                       sxtok_pkg::ERR_OVERFLOW);
         end else begin
            r.st.depth = w.st.depth + 8'd1;
            r = f_emit(r, sxtok_pkg::TOK_OPEN, 8'h00, sxtok_pkg::ATOM_BASIC,
                       sxtok_pkg::ERR_NONE);
         end
      end else if (c == sxtok_pkg::CHAR_RPAREN) begin
         if (w.st.depth == 8'd0) begin
            r = f_emit(r, sxtok_pkg::TOK_ERROR, 8'h00, sxtok_pkg::ATOM_BASIC,
                       sxtok_pkg::ERR_UNMATCHED);
         end else begin
            r.st.depth = w.st.depth - 8'd1;
            r = f_emit(r, sxtok_pkg::TOK_CLOSE, 8'h00, sxtok_pkg::ATOM_BASIC,
                       sxtok_pkg::ERR_NONE);
            if (r.st.depth == 8'd0) begin
               r = f_emit(r, sxtok_pkg::TOK_DONE, 8'h00, sxtok_pkg::ATOM_BASIC,
                          sxtok_pkg::ERR_NONE);
            end
         end
      end else if (c == sxtok_pkg::CHAR_DQUOTE) begin
         r = f_begin(r, sxtok_pkg::MODE_DQ);
      end else if (c == sxtok_pkg::CHAR_SQUOTE) begin
         r.st.mode = sxtok_pkg::MODE_SQ_WAIT;
      end else if (is_atom(c)) begin
         r = f_begin(r, sxtok_pkg::MODE_BASIC);
         r = f_add_byte(r, c, lim);
      end
      return r;
   endfunction

   function automatic work_type f_list(input work_type w, input logic [7:0] c,
                                       input logic [sxtok_pkg::ATOM_LEN_W-1:0] lim);
      work_type r;
      r = w;
      if (c == sxtok_pkg::CHAR_LPAREN) begin
         if (w.st.qdepth != 8'hff) r.st.qdepth = w.st.qdepth + 8'd1;
      end else if (c == sxtok_pkg::CHAR_RPAREN) begin
         if (w.st.qdepth != 8'h00) r.st.qdepth = w.st.qdepth - 8'd1;
      end
      r = f_add_byte(r, c, lim);
      if (c == sxtok_pkg::CHAR_RPAREN && r.st.qdepth == 8'd0) begin
         r = f_end_atom(r, sxtok_pkg::ATOM_SQ);
      end
      return r;
   endfunction

   always_comb begin
      work_type w;
      w.st  = state_i;
      w.tok = '0;
      w.n   = 2'd0;
      case (state_i.mode)
         sxtok_pkg::MODE_BASIC: begin
            if (is_atom(char_i)) begin
               w = f_add_byte(w, char_i, limit_i);
            end else begin
               w = f_end_atom(w, sxtok_pkg::ATOM_BASIC);
               w = f_idle(w, char_i, depth_cap_i, limit_i);
            end
         end
         sxtok_pkg::MODE_DQ: begin
            if (char_i == sxtok_pkg::CHAR_DQUOTE) begin
               w = f_end_atom(w, sxtok_pkg::ATOM_DQ);
            end else begin
               w = f_add_byte(w, char_i, limit_i);
            end
         end
         sxtok_pkg::MODE_SQ_WAIT: begin
            if (char_i == sxtok_pkg::CHAR_DQUOTE) begin
               w = f_begin(w, sxtok_pkg::MODE_DQ);
            end else if (char_i == sxtok_pkg::CHAR_LPAREN) begin
               w = f_begin(w, sxtok_pkg::MODE_SQ_LIST);
               w.st.qdepth = 8'd0;
               w = f_list(w, char_i, limit_i);
            end else if (is_atom(char_i)) begin
               w = f_begin(w, sxtok_pkg::MODE_BASIC);
               w = f_add_byte(w, char_i, limit_i);
            end else begin
               w = f_begin(w, sxtok_pkg::MODE_BASIC);
               w = f_end_atom(w, sxtok_pkg::ATOM_BASIC);
               w = f_idle(w, char_i, depth_cap_i, limit_i);
            end
         end
         sxtok_pkg::MODE_SQ_LIST: begin
            w = f_list(w, char_i, limit_i);
         end
         default: begin
            w = f_idle(w, char_i, depth_cap_i, limit_i);
         end
      endcase
      state_o  = w.st;
      tokens_o = w.tok;
      count_o  = w.n;
   end

endmodule

`default_nettype wire

/* hdl/sexpr_tokenizer_core.sv */
// Top level of the s-expression tokenizer: parse state, token buffer, handshakes.
// Depends on sxtok_pkg and sxtok_step.
//
// Takes one character per req transaction and emits its tokens (none to three) on the
// rsp channel, one per cycle while rsp_tready is high, with rsp_tlast on the final token
// of each character. The parse step for a character is done in the cycle it is accepted,
// and its tokens land in a three-entry buffer. A new character is taken whenever the buffer
// is empty or its final token is being taken, so characters that give at most one token
// flow at one per cycle while rsp_tready is high; a character that gives more than one
// token holds the input until its final token is taken, as the output port carries a
// single token at a time. csr_wdata sets the atom length limit, clamped to 1..MAX_ATOM.
`default_nettype none

module sexpr_tokenizer_core #(
   parameter int MAX_DEPTH = 255,
   parameter int MAX_ATOM  = 4096
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_we,
   input  wire [12:0]  csr_wdata,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [7:0]   req_tdata,   // char_in[7:0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // char_value[7:0], atom_kind[9:8], list_depth[17:10],
                                    // error_code[20:18], zero[23:21]
   output logic [2:0]  rsp_tuser,   // token_kind[2:0]
   output logic        rsp_tlast
);

   localparam logic [7:0] DEPTH_CAP = (MAX_DEPTH < 255) ? 8'(MAX_DEPTH) : 8'd255;
   localparam int RESET_LIMIT = (256 > MAX_ATOM) ? MAX_ATOM : 256;

   sxtok_pkg::state_type                  state_ff, state_in;
   sxtok_pkg::token_list_type             tok_ff, tok_in;
   logic [1:0]                            cnt_ff, cnt_in;
   logic [1:0]                            idx_ff, idx_in;
   logic [sxtok_pkg::ATOM_LEN_W-1:0]      limit_ff, limit_in;

   sxtok_pkg::state_type                  step_state;
   sxtok_pkg::token_list_type             step_tok;
   logic [1:0]                            step_cnt;
   sxtok_pkg::token_type                  cur_tok;
   logic                                  req_fire, rsp_fire, at_last;

   sxtok_step u_step (
      .state_i     (state_ff),
      .char_i      (req_tdata),
      .limit_i     (limit_ff),
      .depth_cap_i (DEPTH_CAP),
      .state_o     (step_state),
      .tokens_o    (step_tok),
      .count_o     (step_cnt)
   );

   assign rsp_tvalid = idx_ff < cnt_ff;
   assign at_last    = (idx_ff + 2'd1) == cnt_ff;
   assign req_tready = !rsp_tvalid || (rsp_tready && at_last);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   assign cur_tok   = tok_ff[idx_ff];
   assign rsp_tdata = {3'b000, cur_tok.err, cur_tok.depth, cur_tok.akind, cur_tok.ch};
   assign rsp_tuser = cur_tok.kind;
   assign rsp_tlast = at_last;

   always_comb begin
      state_in = state_ff;
      tok_in   = tok_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         if (csr_wdata == 13'd0) begin
            limit_in = 13'd1;
         end else if (32'(csr_wdata) > MAX_ATOM) begin
            limit_in = 13'(MAX_ATOM);
         end else begin
            limit_in = csr_wdata;
         end
      end
      if (rsp_fire) begin
         if (at_last) begin
            cnt_in = 2'd0;
            idx_in = 2'd0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (req_fire) begin
         state_in = step_state;
         tok_in   = step_tok;
         cnt_in   = step_cnt;
         idx_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff <= tok_in;
      if (reset) begin
         state_ff.mode   <= sxtok_pkg::MODE_IDLE;
         state_ff.depth  <= '0;
         state_ff.qdepth <= '0;
         state_ff.count  <= '0;
         state_ff.trunc  <= 1'b0;
         cnt_ff          <= 2'd0;
         idx_ff          <= 2'd0;
         limit_ff        <= 13'(RESET_LIMIT);
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         idx_ff   <= idx_in;
         limit_ff <= limit_in;
      end
   end

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd0 |-> idx_ff < cnt_ff)
      else $error("token buffer index past fill");

   a_depth_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff.depth <= DEPTH_CAP)
      else $error("list depth above cap");

   a_burst_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("tokens of one character dropped");

   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || (rsp_tready && rsp_tlast))
      else $error("character accepted over pending tokens");

   a_limit_range: assert property (@(posedge clock) disable iff (reset)
      limit_ff != '0 && 32'(limit_ff) <= MAX_ATOM)
      else $error("atom limit out of range");

endmodule

`default_nettype wire
